// ===== hw/rtl/cosfd_pkg.sv =====
package cosfd_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int COUNT_W        = 5;
    localparam int DATA_START     = 8;

    localparam logic [COUNT_W-1:0] FIXED_BYTES = COUNT_W'(10);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(10 + MAX_DATA_BYTES + 1);

    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_T  = 8'h54;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam int TDATA_W = 96;
    localparam int TUSER_W = 4;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_TOO_SHORT   = 3'd1,
        STATUS_BAD_HEADER  = 3'd2,
        STATUS_BAD_LENGTH  = 3'd3,
        STATUS_BAD_TRAILER = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_APP_CHANNEL    = 2'd0,
        REG_APP_REQUEST_ID = 2'd1
    } reg_index_t;

    typedef struct packed {
        status_t      status;
        logic         is_application;
        logic [63:0]  payload;
        logic [3:0]   dlc;
        logic [15:0]  can_id;
        logic [7:0]   channel;
    } result_t;

endpackage

// ===== hw/rtl/can_over_serial_frame_decoder_top.sv =====
// Serial CAN frame decoder. Takes one frame byte per request on the slave
// stream, with tlast on the final byte, and returns one result per frame on
// the master stream. A byte is taken in every cycle that s_tready is high;
// results pass through a two-entry output buffer, so s_tready drops only
// while two results wait to be taken. Status (tuser[2:0]) reports too short,
// bad header, bad length, bad trailer or ok in that priority; all other fields
// are zero unless the status is ok. tuser[3] flags a frame whose channel and id
// match the app_channel and app_request_id registers, which the user must write
// through the cfg port while no frame is in progress; this is not enforced.
module can_over_serial_frame_decoder_top
    import cosfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte[7:0]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // channel, can_id, dlc, payload, zero pad
    output logic [TUSER_W-1:0] m_tuser    // status[2:0], is_application
);

    logic [7:0]         app_channel_reg;
    logic [15:0]        app_request_id_reg;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               header_good_reg, header_good_next;
    logic [7:0]         held_channel_reg, held_channel_next;
    logic [15:0]        held_id_reg, held_id_next;
    logic [7:0]         held_length_code_reg, held_length_code_next;
    logic [63:0]        held_payload_reg, held_payload_next;
    logic [7:0]         previous_byte_reg, previous_byte_next;

    result_t            main_reg, main_next;
    result_t            skid_reg, skid_next;
    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    logic               in_acc;
    logic               push;
    logic               pop;
    logic [COUNT_W-1:0] total;
    status_t            status;
    result_t            result;

    assign in_acc   = s_tvalid && s_tready;
    assign push     = in_acc && s_tlast;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            app_channel_reg    <= '0;
            app_request_id_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_APP_CHANNEL:    app_channel_reg    <= cfg_wdata[7:0];
                REG_APP_REQUEST_ID: app_request_id_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        total = (byte_count_reg < COUNT_LIMIT) ? byte_count_reg + 1'b1 : byte_count_reg;

        if (total < FIXED_BYTES) begin
            status = STATUS_TOO_SHORT;
        end else if (!header_good_reg) begin
            status = STATUS_BAD_HEADER;
        end else if (held_length_code_reg > 8'(MAX_DATA_BYTES) ||
                     9'(total) != 9'(FIXED_BYTES) + 9'(held_length_code_reg)) begin
            status = STATUS_BAD_LENGTH;
        end else if (previous_byte_reg != CHAR_CR || s_tdata != CHAR_LF) begin
            status = STATUS_BAD_TRAILER;
        end else begin
            status = STATUS_OK;
        end

        result        = '0;
        result.status = status;
        if (status == STATUS_OK) begin
            result.channel        = held_channel_reg;
            result.can_id         = held_id_reg;
            result.dlc            = held_length_code_reg[3:0];
            result.payload        = held_payload_reg;
            result.is_application = (held_channel_reg == app_channel_reg) &&
                                    (held_id_reg == app_request_id_reg);
        end
    end

    always_comb begin
        byte_count_next       = byte_count_reg;
        header_good_next      = header_good_reg;
        held_channel_next     = held_channel_reg;
        held_id_next          = held_id_reg;
        held_length_code_next = held_length_code_reg;
        held_payload_next     = held_payload_reg;
        previous_byte_next    = previous_byte_reg;

        if (in_acc) begin
            if (s_tlast) begin
                byte_count_next       = '0;
                header_good_next      = 1'b1;
                held_channel_next     = '0;
                held_id_next          = '0;
                held_length_code_next = '0;
                held_payload_next     = '0;
                previous_byte_next    = '0;
            end else begin
                byte_count_next    = total;
                previous_byte_next = s_tdata;
                if (byte_count_reg == COUNT_W'(0) && s_tdata != CHAR_S) begin
                    header_good_next = 1'b0;
                end
                if (byte_count_reg == COUNT_W'(1) && s_tdata != CHAR_T) begin
                    header_good_next = 1'b0;
                end
                if (byte_count_reg == COUNT_W'(2)) begin
                    held_channel_next = s_tdata;
                end
                if (byte_count_reg == COUNT_W'(5)) begin
                    held_id_next[15:8] = s_tdata;
                end
                if (byte_count_reg == COUNT_W'(6)) begin
                    held_id_next[7:0] = s_tdata;
                end
                if (byte_count_reg == COUNT_W'(7)) begin
                    held_length_code_next = s_tdata;
                end
                for (int j = 0; j < MAX_DATA_BYTES; j++) begin
                    if (byte_count_reg == COUNT_W'(DATA_START + j) &&
                        8'(j) < held_length_code_reg) begin
                        held_payload_next[8*j +: 8] = s_tdata;
                    end
                end
            end
        end
    end

    // two-entry output buffer: main drives the port, skid catches a result
    // that arrives while main is stalled
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = result;
                main_valid_next = push;
            end
        end else if (push) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg       <= '0;
            header_good_reg      <= 1'b1;
            held_channel_reg     <= '0;
            held_id_reg          <= '0;
            held_length_code_reg <= '0;
            held_payload_reg     <= '0;
            previous_byte_reg    <= '0;
            main_valid_reg       <= 1'b0;
            skid_valid_reg       <= 1'b0;
        end else begin
            byte_count_reg       <= byte_count_next;
            header_good_reg      <= header_good_next;
            held_channel_reg     <= held_channel_next;
            held_id_reg          <= held_id_next;
            held_length_code_reg <= held_length_code_next;
            held_payload_reg     <= held_payload_next;
            previous_byte_reg    <= previous_byte_next;
            main_valid_reg       <= main_valid_next;
            skid_valid_reg       <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {4'b0, main_reg.payload, main_reg.dlc, main_reg.can_id,
                       main_reg.channel};
    assign m_tuser  = {main_reg.is_application, main_reg.status};

endmodule

// ===== hw/rtl/cosfd_checker.sv =====
module cosfd_checker
    import cosfd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0] m_tuser
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] != 3'(STATUS_OK) |-> m_tdata == '0 && !m_tuser[3])
        else $error("failed frame carries nonzero fields");

    a_ok_dlc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == 3'(STATUS_OK) |-> m_tdata[27:24] <= 4'(MAX_DATA_BYTES))
        else $error("ok frame with length code out of range");

endmodule

bind can_over_serial_frame_decoder_top cosfd_checker u_cosfd_checker (.*);
